### rtl/nibble_sbox_substitution_cipher_assert.svh
// Assertion macros shared by the checker of the nibble S-box cipher.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef NIBBLE_SBOX_SUBSTITUTION_CIPHER_ASSERT_SVH
`define NIBBLE_SBOX_SUBSTITUTION_CIPHER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NSUB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NSUB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/nsub_pkg.sv
// Package of the nibble S-box cipher: codes, widths and the structs
// passed between the controller and the top level. No dependencies.
package nsub_pkg;

  localparam int ADDR_W = 10;
  localparam int NIB_W  = 4;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [NIB_W-1:0]  nib_t;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_CHECK = 2'd1;
  localparam logic [1:0] ACT_DATA  = 2'd2;

  localparam logic [1:0] STAT_BYTE    = 2'd0;
  localparam logic [1:0] STAT_KEY_OK  = 2'd1;
  localparam logic [1:0] STAT_KEY_BAD = 2'd2;
  localparam logic [1:0] STAT_REFUSED = 2'd3;

  localparam logic CFG_ENCRYPT = 1'b0;
  localparam logic CFG_BLOCK   = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'h20;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUB,
    ST_PAD_RD,
    ST_PAD_WR,
    ST_CHK_RD,
    ST_CHK_EV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       encrypt;
    logic [5:0] blk_len;
    logic       blk_wr;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
  } res_t;

  typedef struct packed {
    logic  we;
    addr_t addr;
    nib_t  data;
  } mem_wr_t;

  typedef struct packed {
    logic  en;
    addr_t addr_a;
    addr_t addr_b;
  } mem_rd_t;

endpackage

### rtl/nsub_mem.sv
// 1024 x 4 synchronous memory: one write port, two registered read ports.
// Depends on nsub_pkg.
module nsub_mem (
  input  logic             clk,
  input  nsub_pkg::mem_wr_t wr,
  input  nsub_pkg::mem_rd_t rd,
  output nsub_pkg::nib_t   rd_a,
  output nsub_pkg::nib_t   rd_b
);
  import nsub_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  nib_t mem [0:DEPTH-1];
  nib_t rd_a_r;
  nib_t rd_b_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_a_r <= mem[rd.addr_a];
      rd_b_r <= mem[rd.addr_b];
    end
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

### rtl/nsub_ctrl.sv
// Sequencer of the nibble S-box cipher: key loads, key check walk, byte
// substitution and padding, all through the box memories. Depends on nsub_pkg.
module nsub_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_action,
  input  logic [5:0]        in_box_index,
  input  logic [3:0]        in_entry_index,
  input  logic [3:0]        in_key_value,
  input  logic [7:0]        in_data_byte,
  input  logic              in_data_last,
  input  nsub_pkg::cfg_t    cfg,
  input  logic              out_free,
  output nsub_pkg::res_t    res,
  output nsub_pkg::mem_wr_t fwd_wr,
  output nsub_pkg::mem_wr_t inv_wr,
  output nsub_pkg::mem_rd_t mem_rd,
  input  nsub_pkg::nib_t    fwd_rd_a,
  input  nsub_pkg::nib_t    fwd_rd_b,
  input  nsub_pkg::nib_t    inv_rd_a,
  input  nsub_pkg::nib_t    inv_rd_b
);
  import nsub_pkg::*;

  state_t      state_r, state_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [4:0]  pad_pos_r, pad_pos_nxt;
  logic        key_valid_r, key_valid_nxt;
  logic [15:0] seen_r, seen_nxt;
  addr_t       chk_cnt_r, chk_cnt_nxt;
  addr_t       clr_cnt_r, clr_cnt_nxt;
  logic [1:0]  pend_status_r, pend_status_nxt;
  logic        sub_last_r, sub_last_nxt;

  logic        accept;
  logic [4:0]  pos_norm;
  logic [5:0]  pos_inc;
  logic [4:0]  pos_wrap;
  logic [5:0]  pad_inc;
  logic        pad_done;
  logic [5:0]  nbox_m1;
  logic [5:0]  chk_box;
  nib_t        chk_ent;
  logic        chk_dup;
  logic        chk_end;
  logic        refuse;
  logic [7:0]  sub_data;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);

  assign pos_norm = ({1'b0, pos_r} >= cfg.blk_len) ? 5'd0 : pos_r;
  assign pos_inc  = {1'b0, pos_norm} + 6'd1;
  assign pos_wrap = (pos_inc >= cfg.blk_len) ? 5'd0 : pos_inc[4:0];
  assign pad_inc  = {1'b0, pad_pos_r} + 6'd1;
  assign pad_done = (pad_inc >= cfg.blk_len);

  assign nbox_m1  = 6'(({1'b0, cfg.blk_len} << 1) - 7'd1);
  assign chk_box  = chk_cnt_r[ADDR_W-1:NIB_W];
  assign chk_ent  = chk_cnt_r[NIB_W-1:0];
  assign chk_dup  = seen_r[fwd_rd_a];
  assign chk_end  = (chk_box == nbox_m1) && (chk_ent == 4'hF);

  assign refuse   = !cfg.encrypt && !key_valid_r;
  assign sub_data = cfg.encrypt ? {fwd_rd_b, fwd_rd_a} : {inv_rd_b, inv_rd_a};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_CHECK: state_nxt = ST_CHK_RD;
            ACT_DATA:  state_nxt = refuse ? ST_EMIT : ST_SUB;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SUB: begin
        if (out_free) state_nxt = sub_last_r ? ST_IDLE : ST_PAD_RD;
      end
      ST_PAD_RD: state_nxt = ST_PAD_WR;
      ST_PAD_WR: begin
        if (out_free && pad_done) state_nxt = ST_IDLE;
        else if (out_free)        state_nxt = ST_PAD_RD;
      end
      ST_CHK_RD: state_nxt = ST_CHK_EV;
      ST_CHK_EV: begin
        if (chk_dup || chk_end) state_nxt = ST_EMIT;
        else                    state_nxt = ST_CHK_RD;
      end
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath registers.
  always_comb begin
    pos_nxt         = pos_r;
    pad_pos_nxt     = pad_pos_r;
    key_valid_nxt   = key_valid_r;
    seen_nxt        = seen_r;
    chk_cnt_nxt     = chk_cnt_r;
    clr_cnt_nxt     = clr_cnt_r;
    pend_status_nxt = pend_status_r;
    sub_last_nxt    = sub_last_r;
    case (state_r)
      ST_CLEAR: clr_cnt_nxt = clr_cnt_r + addr_t'(1);
      ST_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_LOAD: key_valid_nxt = 1'b0;
            ACT_CHECK: begin
              chk_cnt_nxt = '0;
              seen_nxt    = '0;
            end
            ACT_DATA: begin
              if (refuse) begin
                pend_status_nxt = STAT_REFUSED;
                if (in_data_last) pos_nxt = 5'd0;
              end else if (in_data_last && (pos_wrap != 5'd0)) begin
                sub_last_nxt = 1'b0;
                pad_pos_nxt  = pos_wrap;
                pos_nxt      = 5'd0;
              end else begin
                sub_last_nxt = 1'b1;
                pos_nxt      = pos_wrap;
              end
            end
            default: ;
          endcase
        end
      end
      ST_PAD_WR: begin
        if (out_free) pad_pos_nxt = pad_inc[4:0];
      end
      ST_CHK_EV: begin
        if (chk_dup) begin
          key_valid_nxt   = 1'b0;
          pend_status_nxt = STAT_KEY_BAD;
        end else begin
          // The mask restarts with each box.
          seen_nxt    = (chk_ent == 4'hF) ? 16'd0 : (seen_r | (16'd1 << fwd_rd_a));
          chk_cnt_nxt = chk_cnt_r + addr_t'(1);
          if (chk_end) begin
            key_valid_nxt   = 1'b1;
            pend_status_nxt = STAT_KEY_OK;
          end
        end
      end
      default: ;
    endcase
    if (cfg.blk_wr) begin
      key_valid_nxt = 1'b0;
      pos_nxt       = 5'd0;
    end
  end

  // Memory ports and result.
  always_comb begin
    fwd_wr = '0;
    inv_wr = '0;
    mem_rd = '0;
    res    = '0;
    case (state_r)
      ST_CLEAR: begin
        fwd_wr.we   = 1'b1;
        fwd_wr.addr = clr_cnt_r;
      end
      ST_IDLE: begin
        if (accept && in_action == ACT_LOAD) begin
          fwd_wr.we   = 1'b1;
          fwd_wr.addr = {in_box_index, in_entry_index};
          fwd_wr.data = in_key_value;
        end
        if (accept && in_action == ACT_DATA && !refuse) begin
          mem_rd.en     = 1'b1;
          mem_rd.addr_a = {pos_norm, 1'b0, in_data_byte[3:0]};
          mem_rd.addr_b = {pos_norm, 1'b1, in_data_byte[7:4]};
        end
      end
      ST_SUB: begin
        res.load   = out_free;
        res.data   = sub_data;
        res.status = STAT_BYTE;
        res.last   = sub_last_r;
      end
      ST_PAD_RD: begin
        mem_rd.en     = 1'b1;
        mem_rd.addr_a = {pad_pos_r, 1'b0, PAD_BYTE[3:0]};
        mem_rd.addr_b = {pad_pos_r, 1'b1, PAD_BYTE[7:4]};
      end
      ST_PAD_WR: begin
        res.load   = out_free;
        res.data   = sub_data;
        res.status = STAT_BYTE;
        res.last   = pad_done;
      end
      ST_CHK_RD: begin
        mem_rd.en     = 1'b1;
        mem_rd.addr_a = chk_cnt_r;
        mem_rd.addr_b = chk_cnt_r;
      end
      ST_CHK_EV: begin
        // A box that later fails keeps the inverse entries written so far;
        // they are unreachable because the key stays invalid.
        inv_wr.we   = !chk_dup;
        inv_wr.addr = {chk_box, fwd_rd_a};
        inv_wr.data = chk_ent;
      end
      ST_EMIT: begin
        res.load   = out_free;
        res.data   = 8'd0;
        res.status = pend_status_r;
        res.last   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      pos_r       <= '0;
      key_valid_r <= 1'b0;
      seen_r      <= '0;
      clr_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      key_valid_r <= key_valid_nxt;
      seen_r      <= seen_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pad_pos_r     <= pad_pos_nxt;
    chk_cnt_r     <= chk_cnt_nxt;
    pend_status_r <= pend_status_nxt;
    sub_last_r    <= sub_last_nxt;
  end

endmodule

### rtl/nibble_sbox_substitution_cipher.sv
// Top level of the nibble S-box cipher: configuration registers, box
// memories, sequencer and output register. Depends on nsub_pkg, nsub_mem, nsub_ctrl.
//
//   port group  direction  handshake          carries
//   in_*        input      in_valid/in_stall  action, key entry, data byte, last flag
//   out_*       output     out_valid/out_stall substituted byte or status, last flag
//   cfg_*       input      cfg_we             encrypt_mode, block_bytes_log2
//
// After reset the forward boxes are cleared, one entry a cycle; no word is taken
// until all 1024 are clear. A key load is written as it is taken. A data byte
// reads its two nibble boxes at once; each padding byte takes a read and a write
// state. A key check reads, then checks, each entry of the 2 * block bytes boxes.
// The output register holds a stalled word while the next input is taken.
module nibble_sbox_substitution_cipher #(
  parameter int MAX_BLOCK_BITS = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic [5:0] in_box_index,
  input  logic [3:0] in_entry_index,
  input  logic [3:0] in_key_value,
  input  logic [7:0] in_data_byte,
  input  logic       in_data_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] out_status,
  output logic       out_last,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [2:0] cfg_data
);
  import nsub_pkg::*;

  localparam logic [5:0] CAP_LEN = 6'(MAX_BLOCK_BITS / 8);

  logic       encrypt_r;
  logic [2:0] blk_log2_r;
  logic [2:0] lg_sat;
  logic [5:0] len_pow;
  cfg_t       cfg;
  res_t       res;
  logic       out_free;
  mem_wr_t    fwd_wr, inv_wr;
  mem_rd_t    mem_rd;
  nib_t       fwd_rd_a, fwd_rd_b, inv_rd_a, inv_rd_b;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic [1:0] out_status_r;
  logic       out_last_r;

  assign lg_sat  = (blk_log2_r > 3'd5) ? 3'd5 : blk_log2_r;
  assign len_pow = 6'd1 << lg_sat;

  assign cfg.encrypt = encrypt_r;
  assign cfg.blk_len = (len_pow > CAP_LEN) ? CAP_LEN : len_pow;
  assign cfg.blk_wr  = cfg_we && (cfg_index == CFG_BLOCK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      encrypt_r  <= 1'b1;
      blk_log2_r <= 3'd3;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ENCRYPT) encrypt_r <= cfg_data[0];
      else                          blk_log2_r <= cfg_data;
    end
  end

  nsub_mem u_fwd (
    .clk  (clk),
    .wr   (fwd_wr),
    .rd   (mem_rd),
    .rd_a (fwd_rd_a),
    .rd_b (fwd_rd_b)
  );

  nsub_mem u_inv (
    .clk  (clk),
    .wr   (inv_wr),
    .rd   (mem_rd),
    .rd_a (inv_rd_a),
    .rd_b (inv_rd_b)
  );

  nsub_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_box_index   (in_box_index),
    .in_entry_index (in_entry_index),
    .in_key_value   (in_key_value),
    .in_data_byte   (in_data_byte),
    .in_data_last   (in_data_last),
    .cfg            (cfg),
    .out_free       (out_free),
    .res            (res),
    .fwd_wr         (fwd_wr),
    .inv_wr         (inv_wr),
    .mem_rd         (mem_rd),
    .fwd_rd_a       (fwd_rd_a),
    .fwd_rd_b       (fwd_rd_b),
    .inv_rd_a       (inv_rd_a),
    .inv_rd_b       (inv_rd_b)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      out_byte_r   <= res.data;
      out_status_r <= res.status;
      out_last_r   <= res.last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

### rtl/nsub_checker.sv
// Port-level checker of the nibble S-box cipher and its bind to the top level.
// Depends on nsub_pkg and nibble_sbox_substitution_cipher_assert.svh.
`include "nibble_sbox_substitution_cipher_assert.svh"

module nsub_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_action,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic [1:0] out_status,
  input logic       out_last
);
  import nsub_pkg::*;

  // A stalled result word holds until taken.
  `NSUB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(out_status) && $stable(out_last), "stalled output word changed")

  // Status words carry a zero byte.
  `NSUB_ASSERT_NOW(a_status_zero, out_valid && out_status != STAT_BYTE, out_byte == 8'd0, "status word with nonzero byte")

  // Each status word ends the run of its input.
  `NSUB_ASSERT_NOW(a_status_last, out_valid && out_status != STAT_BYTE, out_last, "status word without last flag")

  // A data or check word always produces results, so the input stalls next.
  `NSUB_ASSERT_NEXT(a_busy_after, in_valid && !in_stall && (in_action == ACT_DATA || in_action == ACT_CHECK), in_stall, "input not stalled while a word is in work")

endmodule

bind nibble_sbox_substitution_cipher nsub_checker u_nsub_checker (.*);
